// ===== sv/point_in_polygon_test_unit_defines.svh =====
// Assertion macros for the point-in-polygon unit.
// No dependencies; taken in by the top level with `include.
`ifndef POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PIPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PIPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pipt_pkg.sv =====
// Shared types, command codes and helpers for the point-in-polygon unit.
// No dependencies; used by pipt_cell, pipt_edge_unit and the top level.
package pipt_pkg;

   localparam int MAX_VERTICES_DEFAULT = 64;
   localparam int COORD_W = 16;
   localparam int WIDE_W  = COORD_W + 1;

   // command codes; code three is unused and only answers
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] offset_x;
      logic signed [COORD_W-1:0] offset_y;
   } req_word_type;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   // sequencer to edge unit
   typedef struct packed {
      logic clear;   // start of query: drop parity
      logic fire;    // one edge presented this cycle
   } edge_ctl_type;

   // edge unit back to sequencer
   typedef struct packed {
      logic parity;  // crossings so far, mod 2
      logic idle;    // no edge left in flight
   } edge_status_type;

   function automatic logic signed [WIDE_W-1:0] sext17(input logic signed [COORD_W-1:0] v);
      sext17 = $signed({v[COORD_W-1], v});
   endfunction

endpackage

// ===== sv/pipt_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// No dependencies; payload types come from pipt_pkg at the instantiation.
interface pipt_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/pipt_cell.sv =====
// One vertex cell of the rotating vertex chain.
// Depends on pipt_pkg for vertex_type.
module pipt_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  pipt_pkg::vertex_type din,
   output pipt_pkg::vertex_type dout
);
   import pipt_pkg::*;

   vertex_type vtx_ff;
   vertex_type vtx_in;

   // take the neighbour's vertex when the chain moves, else hold
   assign vtx_in = shift ? din : vtx_ff;

   always_ff @(posedge clock) begin
      vtx_ff <= vtx_in;
   end

   assign dout = vtx_ff;
endmodule

// ===== sv/pipt_edge_unit.sv =====
// Ray-crossing test for one edge a cycle, three stages, with parity count.
// Depends on pipt_pkg for vertex and control types.
module pipt_edge_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  pipt_pkg::edge_ctl_type        ctl,
   input  pipt_pkg::vertex_type          va,
   input  pipt_pkg::vertex_type          vb,
   input  logic signed [pipt_pkg::WIDE_W-1:0] qx,   // point minus offset
   input  logic signed [pipt_pkg::WIDE_W-1:0] qy,
   output pipt_pkg::edge_status_type     status
);
   import pipt_pkg::*;

   localparam int D_W = WIDE_W + 1;       // differences against the point
   localparam int P_W = WIDE_W + D_W;     // exact products

   // stage 1: differences and straddle flag
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_straddle_ff, s1_straddle_in;
   logic signed [WIDE_W-1:0] dy_ff, dy_in;
   logic signed [WIDE_W-1:0] dx_ff, dx_in;
   logic signed [D_W-1:0]    dxp_ff, dxp_in;
   logic signed [D_W-1:0]    dyp_ff, dyp_in;

   // stage 2: products
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_straddle_ff, s2_straddle_in;
   logic                     s2_dy_pos_ff, s2_dy_pos_in;
   logic signed [P_W-1:0]    lhs_ff, lhs_in;
   logic signed [P_W-1:0]    rhs_ff, rhs_in;

   logic                     parity_ff, parity_in;
   logic                     crossing;

   always_comb begin
      s1_valid_in    = ctl.fire;
      s1_straddle_in = (sext17(va.y) > qy) != (sext17(vb.y) > qy);
      dy_in  = sext17(vb.y) - sext17(va.y);
      dx_in  = sext17(vb.x) - sext17(va.x);
      dxp_in = $signed({qx[WIDE_W-1], qx}) - $signed({{2{va.x[COORD_W-1]}}, va.x});
      dyp_in = $signed({qy[WIDE_W-1], qy}) - $signed({{2{va.y[COORD_W-1]}}, va.y});

      s2_valid_in    = s1_valid_ff;
      s2_straddle_in = s1_straddle_ff;
      s2_dy_pos_in   = !dy_ff[WIDE_W-1] && (dy_ff != '0);
      lhs_in = dxp_ff * dy_ff;
      rhs_in = dx_ff * dyp_ff;

      crossing = s2_dy_pos_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff);
      priority if (ctl.clear) begin
         parity_in = 1'b0;
      end else if (s2_valid_ff && s2_straddle_ff && crossing) begin
         parity_in = !parity_ff;
      end else begin
         parity_in = parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         parity_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         parity_ff   <= parity_in;
      end
      s1_straddle_ff <= s1_straddle_in;
      dy_ff          <= dy_in;
      dx_ff          <= dx_in;
      dxp_ff         <= dxp_in;
      dyp_ff         <= dyp_in;
      s2_straddle_ff <= s2_straddle_in;
      s2_dy_pos_ff   <= s2_dy_pos_in;
      lhs_ff         <= lhs_in;
      rhs_ff         <= rhs_in;
   end

   assign status.parity = parity_ff;
   assign status.idle   = !s1_valid_ff && !s2_valid_ff;
endmodule

// ===== sv/point_in_polygon_test_unit.sv =====
// Point-in-polygon test unit (top level); uses pipt_pkg, pipt_stream_if,
// pipt_cell, pipt_edge_unit and the assertion macros. The unit keeps a polygon of up to
// MAX_VERTICES vertices (signed Q12.4) and its bounding box. Each request word carries a
// command: clear empties the polygon, append adds a vertex (status 1 when the store is
// full and the vertex is dropped), query tests the point coord against the polygon moved
// by offset and answers inside_res; command code three just answers zero. Every request
// gives exactly one response word, in order. Clear, append and the unused code finish in
// the accepting cycle. A query outside the box, or on an empty polygon, answers from the
// box check; any other query answers once one full turn of the vertex chain has passed
// the single edge-test unit (one edge a cycle) and its three-stage pipeline has drained.
// One request is worked on at a time; a finished response waits in an output
// register and a second slot, so the next request is taken while a response is unread.
`include "point_in_polygon_test_unit_defines.svh"

module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   pipt_stream_if.sink   req_if,
   pipt_stream_if.source rsp_if
);
   import pipt_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int ROT_W = $clog2(MAX_VERTICES);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_VERTICES);
   localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(MAX_VERTICES - 1);
   localparam logic [CNT_W:0]   TURN     = (CNT_W + 1)'(MAX_VERTICES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOX,
      ST_ROTATE,
      ST_CLOSE,
      ST_DRAIN
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [COORD_W-1:0] box_min_x_ff, box_min_x_in;
   logic signed [COORD_W-1:0] box_max_x_ff, box_max_x_in;
   logic signed [COORD_W-1:0] box_min_y_ff, box_min_y_in;
   logic signed [COORD_W-1:0] box_max_y_ff, box_max_y_in;
   logic signed [WIDE_W-1:0]  qx_ff, qx_in;
   logic signed [WIDE_W-1:0]  qy_ff, qy_in;
   logic [ROT_W-1:0]          rot_ff, rot_in;
   vertex_type                prev_ff, prev_in;
   vertex_type                first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;
   logic                      pend_valid_ff, pend_valid_in;
   rsp_word_type              pend_word_ff, pend_word_in;

   logic            req_accept;
   logic            out_free;
   logic            deliver;
   rsp_word_type    res;
   logic            chain_shift;
   vertex_type      chain_head;
   vertex_type      new_vtx;
   vertex_type      tail;
   vertex_type      edge_a, edge_b;
   logic [CNT_W:0]  tail_pos;
   logic            tail_valid;
   logic            tail_first;
   logic            outside_box;
   edge_ctl_type    edge_ctl;
   edge_status_type edge_st;
   logic            box_ordered;
   logic            append_grows;
   logic [CNT_W-1:0] cnt_step;

   vertex_type link [MAX_VERTICES];

   assign req_accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign new_vtx.x = req_if.payload.coord_x;
   assign new_vtx.y = req_if.payload.coord_y;

   // Vertex chain: cell 0 holds the newest vertex, cell n-1 the oldest. Appends push in
   // at cell 0; a query turns the whole chain once, feeding the last cell back to cell 0,
   // so it ends as it started and the valid vertices leave the tail oldest first.
   assign tail = link[MAX_VERTICES-1];

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_chain
      if (k == 0) begin : g_head
         pipt_cell u_cell (
            .clock (clock),
            .shift (chain_shift),
            .din   (chain_head),
            .dout  (link[k])
         );
      end else begin : g_body
         pipt_cell u_cell (
            .clock (clock),
            .shift (chain_shift),
            .din   (link[k-1]),
            .dout  (link[k])
         );
      end
   end

   // During the turn, step t shows old cell MAX-1-t at the tail: valid once t + n
   // reaches MAX, and the very first of those is vertex 0.
   assign tail_pos   = (CNT_W + 1)'(rot_ff) + (CNT_W + 1)'(cnt_ff);
   assign tail_valid = tail_pos >= TURN;
   assign tail_first = tail_pos == TURN;

   assign outside_box = (qx_ff < sext17(box_min_x_ff)) || (qx_ff > sext17(box_max_x_ff)) ||
                        (qy_ff < sext17(box_min_y_ff)) || (qy_ff > sext17(box_max_y_ff));

   // closing edge pairs the last vertex with the first
   assign edge_a = prev_ff;
   assign edge_b = (state_ff == ST_CLOSE) ? first_ff : tail;

   pipt_edge_unit u_edge (
      .clock  (clock),
      .reset  (reset),
      .ctl    (edge_ctl),
      .va     (edge_a),
      .vb     (edge_b),
      .qx     (qx_ff),
      .qy     (qy_ff),
      .status (edge_st)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      box_min_x_in  = box_min_x_ff;
      box_max_x_in  = box_max_x_ff;
      box_min_y_in  = box_min_y_ff;
      box_max_y_in  = box_max_y_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      rot_in        = rot_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      deliver       = 1'b0;
      res           = '0;
      chain_shift   = 1'b0;
      chain_head    = tail;
      edge_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_if.payload.cmd)
                  CMD_CLEAR: begin
                     deliver      = 1'b1;
                     cnt_in       = '0;
                     box_min_x_in = '0;
                     box_max_x_in = '0;
                     box_min_y_in = '0;
                     box_max_y_in = '0;
                  end
                  CMD_APPEND: begin
                     deliver = 1'b1;
                     if (cnt_ff == FULL_CNT) begin
                        res.status = 1'b1;     // store full, vertex dropped
                     end else begin
                        chain_shift = 1'b1;
                        chain_head  = new_vtx;
                        cnt_in      = cnt_ff + CNT_W'(1);
                        if (cnt_ff == '0) begin
                           box_min_x_in = new_vtx.x;
                           box_max_x_in = new_vtx.x;
                           box_min_y_in = new_vtx.y;
                           box_max_y_in = new_vtx.y;
                        end else begin
                           if (new_vtx.x < box_min_x_ff) box_min_x_in = new_vtx.x;
                           if (new_vtx.x > box_max_x_ff) box_max_x_in = new_vtx.x;
                           if (new_vtx.y < box_min_y_ff) box_min_y_in = new_vtx.y;
                           if (new_vtx.y > box_max_y_ff) box_max_y_in = new_vtx.y;
                        end
                     end
                  end
                  CMD_QUERY: begin
                     // work in polygon-local frame: point minus offset, exact in 17 bits
                     qx_in = sext17(req_if.payload.coord_x) - sext17(req_if.payload.offset_x);
                     qy_in = sext17(req_if.payload.coord_y) - sext17(req_if.payload.offset_y);
                     edge_ctl.clear = 1'b1;
                     state_in       = ST_BOX;
                  end
                  default: begin
                     deliver = 1'b1;
                  end
               endcase
            end
         end
         ST_BOX: begin
            if ((cnt_ff == '0) || outside_box) begin
               deliver  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rot_in   = '0;
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            chain_shift = 1'b1;
            if (tail_valid) begin
               prev_in = tail;
               if (tail_first) begin
                  first_in = tail;
               end else begin
                  edge_ctl.fire = 1'b1;
               end
            end
            if (rot_ff == ROT_LAST) begin
               state_in = ST_CLOSE;
            end else begin
               rot_in = rot_ff + ROT_W'(1);
            end
         end
         ST_CLOSE: begin
            edge_ctl.fire = 1'b1;
            state_in      = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (edge_st.idle) begin
               deliver        = 1'b1;
               res.inside_res = edge_st.parity;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // two-word response buffer: output register plus one spare slot
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      priority if (pend_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = pend_word_ff;
            pend_valid_in = 1'b0;
         end
      end else if (deliver) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = res;
         end else begin
            pend_valid_in = 1'b1;
            pend_word_in  = res;
         end
      end else begin
         pend_valid_in = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         box_min_x_ff  <= '0;
         box_max_x_ff  <= '0;
         box_min_y_ff  <= '0;
         box_max_y_ff  <= '0;
         rot_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         box_min_x_ff  <= box_min_x_in;
         box_max_x_ff  <= box_max_x_in;
         box_min_y_ff  <= box_min_y_in;
         box_max_y_ff  <= box_max_y_in;
         rot_ff        <= rot_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      rsp_word_ff  <= rsp_word_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_word_ff;

   // checks
   assign box_ordered  = (box_min_x_ff <= box_max_x_ff) && (box_min_y_ff <= box_max_y_ff);
   assign append_grows = req_accept && (req_if.payload.cmd == CMD_APPEND) &&
                         (cnt_ff != FULL_CNT);
   assign cnt_step     = cnt_ff + CNT_W'(1);

   `PIPT_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= FULL_CNT, "count past capacity")
   `PIPT_ASSERT_NOW(a_pend_order, clock, reset, pend_valid_ff, rsp_valid_ff, "slot order")
   `PIPT_ASSERT_NOW(a_box_order, clock, reset, cnt_ff != '0, box_ordered, "box inverted")
   `PIPT_ASSERT_NEXT(a_append_count, clock, reset, append_grows, cnt_ff == $past(cnt_step), "append lost")
endmodule
